>>> sv/qlearning_slot_selector_defines.svh
// ---------------------------------------------------------------------------
// qlearning slot selector assertion macros
// concurrent checks on clk, quiet while rst_n is low
// ---------------------------------------------------------------------------
`ifndef QLEARNING_SLOT_SELECTOR_DEFINES_SVH
`define QLEARNING_SLOT_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QSS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qss check failed");

// next-cycle implication
`define QSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qss check failed");

`else

`define QSS_ASSERT_IMPL(name, ante, cons)
`define QSS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> sv/qss_pkg.sv
// ---------------------------------------------------------------------------
// qss_pkg
// shared constants and types of the q-learning slot selector
// ---------------------------------------------------------------------------
package qss_pkg;

    localparam int SLOT_W    = 4;   // width of slot index fields
    localparam int RATE_W    = 16;  // q0.16 rates
    localparam int FIELD_W   = 16;  // q6.10 value fields
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EPSILON_MAX     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_NUMERATOR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REWARD_SUCCESS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REWARD_FAILURE  = 3'd5;

    // register reset values
    localparam logic [RATE_W-1:0]         RST_LEARNING_RATE   = 16'd6554;
    localparam logic [RATE_W-1:0]         RST_DISCOUNT        = 16'd62259;
    localparam logic [RATE_W-1:0]         RST_EPSILON_MAX     = 16'd32768;
    localparam logic [RATE_W-1:0]         RST_DECAY_NUMERATOR = 16'd10000;
    localparam logic signed [FIELD_W-1:0] RST_REWARD_SUCCESS  = 16'sd0;
    localparam logic signed [FIELD_W-1:0] RST_REWARD_FAILURE  = -16'sd1024;

    // item commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // transmit outcome codes
    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_SUCCESS = 2'd1;

    // rounding bias for q0.16 products
    localparam int ROUND_BIAS = 32768;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

>>> sv/qss_table.sv
// ---------------------------------------------------------------------------
// qss_table
// q value store: one write and one registered read port, zero until written
// ---------------------------------------------------------------------------
module qss_table #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qss_pkg::mem_ctl_t            ctl,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic signed [VALUE_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic signed [VALUE_BITS-1:0] rd_data
);

    logic signed [VALUE_BITS-1:0] mem [SLOTS];
    logic [SLOTS-1:0]             valid_reg;
    logic signed [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/qlearning_slot_selector.sv
// ---------------------------------------------------------------------------
// qlearning_slot_selector
// epsilon-greedy q-learning choice of the transmit slot of a slotframe
// ---------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  item      item_valid/item_stall   command tx_outcome rand_* explore_slot
//                                    entry_index entry_value
//  result    result_valid/           slot old_slot slot_changed explored
//            result_stall            updated new_value
//  config    cfg_valid/cfg_ready     cfg_index cfg_data
//
//  a table write or a tick without outcome goes from idle straight to done
//  a learning tick scans, drains, multiplies twice, writes back and, when it
//  exploits, scans again; each argmax scan reads the start entry, then every entry
//  reset clears the table through per-entry valid bits, no clearing pass
//  the result register lets the next item in while a result is stalled; a
//  finished item waits in its last cycle only if the earlier result is stuck
//
`include "qlearning_slot_selector_defines.svh"

module qlearning_slot_selector #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 command,
    input  logic [1:0]                           tx_outcome,
    input  logic [qss_pkg::RATE_W-1:0]           rand_policy,
    input  logic [qss_pkg::SLOT_W-1:0]           rand_start_update,
    input  logic [qss_pkg::SLOT_W-1:0]           rand_start_select,
    input  logic [qss_pkg::SLOT_W-1:0]           explore_slot,
    input  logic [qss_pkg::SLOT_W-1:0]           entry_index,
    input  logic signed [qss_pkg::FIELD_W-1:0]   entry_value,

    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [qss_pkg::SLOT_W-1:0]           slot,
    output logic [qss_pkg::SLOT_W-1:0]           old_slot,
    output logic                                 slot_changed,
    output logic                                 explored,
    output logic                                 updated,
    output logic signed [qss_pkg::FIELD_W-1:0]   new_value,

    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qss_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [qss_pkg::RATE_W-1:0]           cfg_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    // arithmetic width: value or reward width plus headroom for the update
    localparam int AW    = ((VALUE_BITS > qss_pkg::FIELD_W) ? VALUE_BITS
                                                            : qss_pkg::FIELD_W) + 6;
    localparam int PW    = AW + qss_pkg::RATE_W + 1;
    localparam int EPW   = 2 * qss_pkg::RATE_W + 1;
    localparam int MOD_STEPS = (1 << qss_pkg::SLOT_W) / 2;

    localparam logic signed [AW-1:0] Q_HI = (AW'(1) <<< (VALUE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] Q_LO = -Q_HI - AW'(1);

    // state codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN1  = 4'd1;
    localparam logic [3:0] ST_DRAIN1 = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_WRITE  = 4'd5;
    localparam logic [3:0] ST_SCAN2  = 4'd6;
    localparam logic [3:0] ST_DRAIN2 = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // slot field modulo SLOTS, repeated subtract on a 4-bit value
    function automatic logic [IDX_W-1:0] mod_slots(input logic [qss_pkg::SLOT_W-1:0] v);
        logic [qss_pkg::SLOT_W-1:0] r;
        r = v;
        for (int k = 0; k < MOD_STEPS; k++)
        begin
            if (32'(r) >= SLOTS)
            begin
                r = r - qss_pkg::SLOT_W'(SLOTS);
            end
        end
        return IDX_W'(r);
    endfunction

    // clamp to the signed q value range
    function automatic logic signed [VALUE_BITS-1:0] sat_q(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = v;
        if (v > Q_HI)
        begin
            c = Q_HI;
        end
        else if (v < Q_LO)
        begin
            c = Q_LO;
        end
        return VALUE_BITS'(c);
    endfunction

    // configuration registers
    logic [qss_pkg::RATE_W-1:0]         lr_reg;
    logic [qss_pkg::RATE_W-1:0]         disc_reg;
    logic [qss_pkg::RATE_W-1:0]         emax_reg;
    logic [qss_pkg::RATE_W-1:0]         decay_reg;
    logic signed [qss_pkg::FIELD_W-1:0] rs_reg;
    logic signed [qss_pkg::FIELD_W-1:0] rf_reg;

    // control
    logic [3:0]             state_reg,  state_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]       start_reg,  start_next;
    logic                   rd_vld_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic [IDX_W-1:0]       cur_slot_reg, cur_slot_next;
    logic [qss_pkg::RATE_W-1:0] tick_reg, tick_next;
    logic                   result_valid_reg, result_valid_next;

    // item fields held over the item's work
    logic                   tick_item_reg;
    logic                   success_reg;
    logic [qss_pkg::RATE_W-1:0] rand_reg;
    logic [IDX_W-1:0]       sel_start_reg;
    logic [IDX_W-1:0]       expl_idx_reg;

    // datapath
    logic signed [VALUE_BITS-1:0] best_val_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic signed [VALUE_BITS-1:0] q_old_reg;
    logic signed [PW-1:0]         prod_reg,  prod_next;
    logic [EPW-1:0]               eprod_reg;
    logic signed [VALUE_BITS-1:0] newv_reg;
    logic                         explored_reg, explored_next;
    logic                         updated_reg;

    // result register
    logic [qss_pkg::SLOT_W-1:0]         res_slot_reg;
    logic [qss_pkg::SLOT_W-1:0]         res_old_reg;
    logic                               res_changed_reg;
    logic                               res_explored_reg;
    logic                               res_updated_reg;
    logic signed [qss_pkg::FIELD_W-1:0] res_value_reg;

    // table port
    qss_pkg::mem_ctl_t            mem_ctl;
    logic [IDX_W-1:0]             mem_wr_addr;
    logic signed [VALUE_BITS-1:0] mem_wr_data;
    logic [IDX_W-1:0]             mem_rd_addr;
    logic signed [VALUE_BITS-1:0] mem_rd_data;

    logic item_accept;
    logic result_load;
    logic cfg_write;
    logic [CNT_W-1:0] scan_m1;
    logic [CNT_W-1:0] rd_m1;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] final_slot;

    // arithmetic intermediates
    logic signed [AW-1:0] expected;
    logic signed [PW-1:0] rounded;
    logic signed [AW-1:0] scaled;
    logic signed [AW-1:0] reward;
    logic signed [AW-1:0] diff;
    logic signed [AW-1:0] q_sum;
    logic signed [PW-1:0] rate_disc;
    logic signed [PW-1:0] rate_lr;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_load  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    assign scan_m1 = scan_cnt_reg - CNT_W'(1);
    assign rd_m1   = rd_cnt_reg - CNT_W'(1);
    assign rd_idx  = rd_m1[IDX_W-1:0];

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= qss_pkg::RST_LEARNING_RATE;
            disc_reg  <= qss_pkg::RST_DISCOUNT;
            emax_reg  <= qss_pkg::RST_EPSILON_MAX;
            decay_reg <= qss_pkg::RST_DECAY_NUMERATOR;
            rs_reg    <= qss_pkg::RST_REWARD_SUCCESS;
            rf_reg    <= qss_pkg::RST_REWARD_FAILURE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                qss_pkg::REG_LEARNING_RATE:   lr_reg    <= cfg_data;
                qss_pkg::REG_DISCOUNT:        disc_reg  <= cfg_data;
                qss_pkg::REG_EPSILON_MAX:     emax_reg  <= cfg_data;
                qss_pkg::REG_DECAY_NUMERATOR: decay_reg <= cfg_data;
                qss_pkg::REG_REWARD_SUCCESS:  rs_reg    <= $signed(cfg_data);
                qss_pkg::REG_REWARD_FAILURE:  rf_reg    <= $signed(cfg_data);
                default:                      ;  // writes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // q table
    // ------------------------------------------------------------------
    qss_table #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // update arithmetic
    // rate products round to nearest, ties up: (p + 2^15) >>> 16
    // ------------------------------------------------------------------
    assign rate_disc = PW'($signed({1'b0, disc_reg}));
    assign rate_lr   = PW'($signed({1'b0, lr_reg}));
    assign expected  = AW'(best_val_reg) + AW'(rs_reg);
    assign rounded   = prod_reg + PW'(qss_pkg::ROUND_BIAS);
    assign scaled    = AW'(rounded >>> qss_pkg::RATE_W);
    assign reward    = success_reg ? AW'(rs_reg) : AW'(rf_reg);
    assign diff      = reward + scaled - AW'(q_old_reg);
    assign q_sum     = AW'(q_old_reg) + scaled;

    always_comb
    begin
        prod_next = prod_reg;
        case (state_reg)
            ST_MUL1:  prod_next = PW'(expected) * rate_disc;  // discount * (best + success reward)
            ST_MUL2:  prod_next = PW'(diff) * rate_lr;        // lr * (target - q)
            default:  prod_next = prod_reg;
        endcase
    end

    // explore when rand < min(eps_max, floor(decay*2^16 / ticks)), i.e. when
    // rand < eps_max and (rand + 1) * ticks <= decay * 2^16, no divider needed
    always_comb
    begin
        explored_next = (rand_reg < emax_reg) &&
                        ((tick_reg == '0) ||
                         (eprod_reg <= EPW'({decay_reg, {qss_pkg::RATE_W{1'b0}}})));
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign final_slot = !updated_reg ? cur_slot_reg :
                        (explored_reg ? expl_idx_reg : best_idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        start_next        = start_reg;
        cur_slot_next     = cur_slot_reg;
        tick_next         = tick_reg;
        result_valid_next = result_valid_reg;
        mem_ctl.wr_en     = 1'b0;
        mem_ctl.rd_en     = 1'b0;
        mem_wr_addr       = mod_slots(entry_index);
        mem_wr_data       = sat_q(AW'(entry_value));
        mem_rd_addr       = (scan_cnt_reg == '0) ? start_reg : scan_m1[IDX_W-1:0];

        // result register drains independently of the sequencer
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (command == qss_pkg::CMD_WRITE)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else if (tx_outcome == qss_pkg::OUTCOME_NONE)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        scan_cnt_next = '0;
                        start_next    = mod_slots(rand_start_update);
                        state_next    = ST_SCAN1;
                    end
                end
            end
            ST_SCAN1, ST_SCAN2:
            begin
                // read the start entry, then entries 0 .. SLOTS-1
                mem_ctl.rd_en = 1'b1;
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(SLOTS))
                begin
                    state_next = (state_reg == ST_SCAN1) ? ST_DRAIN1 : ST_DRAIN2;
                end
            end
            ST_DRAIN1:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = cur_slot_reg;
                mem_wr_data   = sat_q(q_sum);
                if (explored_next)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_cnt_next = '0;
                    start_next    = sel_start_reg;
                    state_next    = ST_SCAN2;
                end
            end
            ST_DRAIN2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (result_load)
                begin
                    result_valid_next = 1'b1;
                    cur_slot_next     = final_slot;
                    if (tick_item_reg)
                    begin
                        tick_next = tick_reg + qss_pkg::RATE_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_cnt_reg     <= '0;
            start_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            rd_cnt_reg       <= '0;
            cur_slot_reg     <= '0;
            tick_reg         <= '0;
            result_valid_reg <= 1'b0;
            updated_reg      <= 1'b0;
            explored_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_cnt_reg     <= scan_cnt_next;
            start_reg        <= start_next;
            rd_vld_reg       <= mem_ctl.rd_en;
            rd_cnt_reg       <= scan_cnt_reg;
            cur_slot_reg     <= cur_slot_next;
            tick_reg         <= tick_next;
            result_valid_reg <= result_valid_next;
            if (item_accept)
            begin
                updated_reg  <= (command == qss_pkg::CMD_TICK) &&
                                (tx_outcome != qss_pkg::OUTCOME_NONE);
                explored_reg <= 1'b0;
            end
            else if (state_reg == ST_WRITE)
            begin
                explored_reg <= explored_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // item fields and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            tick_item_reg <= (command == qss_pkg::CMD_TICK);
            success_reg   <= (tx_outcome == qss_pkg::OUTCOME_SUCCESS);
            rand_reg      <= rand_policy;
            sel_start_reg <= mod_slots(rand_start_select);
            expl_idx_reg  <= mod_slots(explore_slot);
            newv_reg      <= '0;
        end

        // scan compare: first read seeds the maximum with the start entry
        if (rd_vld_reg)
        begin
            if (rd_cnt_reg == '0)
            begin
                best_val_reg <= mem_rd_data;
                best_idx_reg <= start_reg;
            end
            else
            begin
                if (mem_rd_data > best_val_reg)
                begin
                    best_val_reg <= mem_rd_data;
                    best_idx_reg <= rd_idx;
                end
                if (rd_idx == cur_slot_reg)
                begin
                    q_old_reg <= mem_rd_data;
                end
            end
        end

        prod_reg <= prod_next;

        if (state_reg == ST_MUL1)
        begin
            eprod_reg <= EPW'({1'b0, rand_reg} + 17'd1) * EPW'(tick_reg);
        end

        if (state_reg == ST_WRITE)
        begin
            newv_reg <= sat_q(q_sum);
        end

        if (result_load)
        begin
            res_slot_reg     <= qss_pkg::SLOT_W'(final_slot);
            res_old_reg      <= qss_pkg::SLOT_W'(cur_slot_reg);
            res_changed_reg  <= (final_slot != cur_slot_reg);
            res_explored_reg <= explored_reg;
            res_updated_reg  <= updated_reg;
            res_value_reg    <= qss_pkg::FIELD_W'(newv_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign slot         = res_slot_reg;
    assign old_slot     = res_old_reg;
    assign slot_changed = res_changed_reg;
    assign explored     = res_explored_reg;
    assign updated      = res_updated_reg;
    assign new_value    = res_value_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the table is never read and written in one cycle
    `QSS_ASSERT_IMPL(a_port_exclusive, mem_ctl.wr_en, !mem_ctl.rd_en)

    // after the write-back either the select scan runs or the item finishes
    `QSS_ASSERT_NEXT(a_write_then, state_reg == ST_WRITE, state_reg == ST_SCAN2 || state_reg == ST_DONE)

    // a loaded result shows the slot that is now in use
    `QSS_ASSERT_NEXT(a_slot_tracks, result_load, result_valid && (slot == qss_pkg::SLOT_W'(cur_slot_reg)))

endmodule
